// ----- hw/rtl/jbr_pkg.sv -----
// Shared types and constants for the jitter buffer reorder block.
`default_nettype none
package jbr_pkg;

  localparam int DEPTH_DEF = 64;
  localparam logic [6:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_GET   = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_REJECTED  = 3'd1,
    ST_DELIVERED = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_LOST      = 3'd4,
    ST_FLUSHED   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_GET_RD,
    S_GET_CMP,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] seq_in;
    logic [31:0] tag_in;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] seq_out;
    logic [31:0] tag_out;
    logic [6:0]  fill;
  } out_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] tag;
  } ent_t;

endpackage
`default_nettype wire

// ----- hw/rtl/jitter_buffer_reorder_core.sv -----
// Top level of the jitter buffer: sorted circular store with a step sequencer.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | in_item  (opcode, seq_in, tag_in)
//   out     | output    | out_valid / out_stall| out_item (status, seq_out, tag_out, fill)
//   cfg     | input     | APB write/read       | capacity at byte address 0
//
// A rejected add, a flush and an unused opcode go straight to the result; an
// accepted add walks down from the tail, moving each held entry with a larger
// number up one slot, and writes the new entry into the gap.
// A get drops stale entries at the head, then delivers the head, reports the
// expected number lost, or reports an empty store.
// One memory port pair (one read, one write per cycle) serves these steps.
// Reset empties the store and clears the expected number; no clearing pass.
// in_stall stays high while an item is in work or its result is not taken.
`default_nettype none
module jitter_buffer_reorder_core #(
  parameter int DEPTH = jbr_pkg::DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire jbr_pkg::in_t  in_item,
  output logic               out_valid,
  input  wire logic          out_stall,
  output jbr_pkg::out_t      out_item,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import jbr_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  state_t          state, state_next;
  logic [6:0]      capacity;
  logic [CW-1:0]   count, count_next;
  logic [AW-1:0]   head, head_next;
  logic [CW-1:0]   pos, pos_next;
  logic [31:0]     expected, expected_next;
  logic            exp_set, exp_set_next;
  logic [31:0]     cur_seq, cur_seq_next;
  logic [31:0]     cur_tag, cur_tag_next;
  out_t            result, result_next;

  ent_t            mem [DEPTH];
  ent_t            rd_data;
  logic            we;
  logic [AW-1:0]   wa, ra;
  ent_t            wd;

  logic            accept;
  logic            full;
  logic [31:0]     exp_eff;

  // Physical slot of a logical offset from the head.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, h} + (AW+1)'(off);
    if (32'(s) >= DEPTH) s = s - (AW+1)'(DEPTH);
    return AW'(s);
  endfunction

  // APB configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? {25'd0, capacity} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && paddr == 3'd0) begin
      capacity <= pwdata[6:0];
    end
  end

  // Store memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ra];
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_item  = result;
  assign accept    = in_valid && !in_stall;

  assign full    = (32'(count) >= 32'(capacity)) || (32'(count) >= DEPTH);
  assign exp_eff = exp_set ? expected : in_item.seq_in;

  // State and data registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      head     <= '0;
      expected <= '0;
      exp_set  <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      head     <= head_next;
      expected <= expected_next;
      exp_set  <= exp_set_next;
    end
    pos     <= pos_next;
    cur_seq <= cur_seq_next;
    cur_tag <= cur_tag_next;
    result  <= result_next;
  end

  // Sequencer: insert walks down from the tail, get drops stale heads.
  always_comb begin
    state_next    = state;
    count_next    = count;
    head_next     = head;
    pos_next      = pos;
    expected_next = expected;
    exp_set_next  = exp_set;
    cur_seq_next  = cur_seq;
    cur_tag_next  = cur_tag;
    result_next   = result;
    we            = 1'b0;
    wa            = slot(head, pos);
    wd            = '{seq: cur_seq, tag: cur_tag};
    ra            = slot(head, pos - CW'(1));

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cur_seq_next = in_item.seq_in;
          cur_tag_next = in_item.tag_in;
          result_next  = '{status: ST_REJECTED, seq_out: 32'd0, tag_out: 32'd0,
                            fill: 7'(count)};
          state_next   = S_OUT;
          unique case (op_t'(in_item.opcode))
            OP_ADD: begin
              expected_next = exp_eff;
              exp_set_next  = 1'b1;
              if (!(in_item.seq_in < exp_eff) && !full) begin
                pos_next   = count;
                state_next = S_INS_RD;
              end
            end
            OP_GET: begin
              state_next = S_GET_RD;
            end
            OP_FLUSH: begin
              count_next         = '0;
              head_next          = '0;
              expected_next      = '0;
              exp_set_next       = 1'b0;
              result_next.status = ST_FLUSHED;
              result_next.fill   = 7'd0;
            end
            default: begin
            end
          endcase
        end
      end
      S_INS_RD: begin
        if (pos == '0) begin
          we                 = 1'b1;
          wa                 = head;
          count_next         = count + CW'(1);
          result_next.status = ST_ACCEPTED;
          result_next.fill   = 7'(count + CW'(1));
          state_next         = S_OUT;
        end else begin
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        we = 1'b1;
        if (rd_data.seq > cur_seq) begin
          wd         = rd_data;
          pos_next   = pos - CW'(1);
          state_next = S_INS_RD;
        end else begin
          count_next         = count + CW'(1);
          result_next.status = ST_ACCEPTED;
          result_next.fill   = 7'(count + CW'(1));
          state_next         = S_OUT;
        end
      end
      S_GET_RD: begin
        ra = head;
        if (count == '0) begin
          result_next.status = ST_EMPTY;
          result_next.fill   = 7'd0;
          state_next         = S_OUT;
        end else begin
          state_next = S_GET_CMP;
        end
      end
      S_GET_CMP: begin
        ra = head;
        if (rd_data.seq < expected) begin
          head_next  = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
          count_next = count - CW'(1);
          state_next = S_GET_RD;
        end else if (rd_data.seq == expected) begin
          head_next     = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
          count_next    = count - CW'(1);
          expected_next = expected + 32'd1;
          result_next   = '{status: ST_DELIVERED, seq_out: rd_data.seq,
                            tag_out: rd_data.tag, fill: 7'(count - CW'(1))};
          state_next    = S_OUT;
        end else begin
          expected_next = expected + 32'd1;
          result_next   = '{status: ST_LOST, seq_out: expected, tag_out: 32'd0,
                            fill: 7'(count)};
          state_next    = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/jbr_checker.sv -----
// Port-level checks for the jitter buffer, bound to the top level.
`default_nettype none
module jbr_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire jbr_pkg::out_t out_item
);
  import jbr_pkg::*;

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // One item at a time: an accepted item blocks the input next cycle.
  a_one: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while busy");

  // Only a delivery carries a handle.
  a_tag: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != ST_DELIVERED |-> out_item.tag_out == 32'd0)
    else $error("handle on non-delivery");

  // A flush leaves the store empty.
  a_flush: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == ST_FLUSHED |-> out_item.fill == 7'd0)
    else $error("flush left entries");
endmodule

bind jitter_buffer_reorder_core jbr_checker u_jbr_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);
`default_nettype wire
